>>> rtl/core/ifs_pkg.sv
// Shared types and constants for the IFS field splitter.
package ifs_pkg;

   // Widths fixed by the stream format
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned MASK_W  = 64;
   localparam int unsigned CSR_IDX_W = 2;

   // Character codes; space, tab and newline are white IFS when their mask bit is set
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // Mask register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_3 = 2'd3;

   // Reset of mask 0: tab, newline and space
   localparam logic [MASK_W-1:0] MASK_0_RESET = 64'h0000_0001_0000_0600;
   localparam logic [MASK_W-1:0] MASK_N_RESET = 64'h0;

   // Input action codes
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // Byte class
   typedef enum logic [1:0] {
      CLS_OTHER    = 2'd0,
      CLS_WHITE    = 2'd1,
      CLS_NONWHITE = 2'd2
   } cls_type;

   // Splitter mode, one-hot
   typedef enum logic [3:0] {
      MODE_LEAD       = 4'b0001,
      MODE_FIELD      = 4'b0010,
      MODE_DELIM_PRE  = 4'b0100,
      MODE_DELIM_POST = 4'b1000
   } mode_type;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] text_byte;
   } req_payload_type;

   typedef struct packed {
      logic               has_byte;
      logic [BYTE_W-1:0]  out_byte;
      logic               field_end;
      logic               text_end;
      logic [COUNT_W-1:0] field_total;
   } rsp_payload_type;

endpackage

>>> rtl/core/ifs_classifier.sv
// IFS mask registers and byte classification.
module ifs_classifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ifs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ifs_pkg::MASK_W-1:0]       csr_wdata,
   input  logic [ifs_pkg::BYTE_W-1:0]       text_byte,
   output ifs_pkg::cls_type                 byte_cls
);

   logic [ifs_pkg::MASK_W-1:0] mask0_ff, mask1_ff, mask2_ff, mask3_ff;
   logic [4*ifs_pkg::MASK_W-1:0] mask_all;
   logic is_member;
   logic is_white;

   // Mask register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mask0_ff <= ifs_pkg::MASK_0_RESET;
         mask1_ff <= ifs_pkg::MASK_N_RESET;
         mask2_ff <= ifs_pkg::MASK_N_RESET;
         mask3_ff <= ifs_pkg::MASK_N_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ifs_pkg::CSR_MASK_0: mask0_ff <= csr_wdata;
            ifs_pkg::CSR_MASK_1: mask1_ff <= csr_wdata;
            ifs_pkg::CSR_MASK_2: mask2_ff <= csr_wdata;
            ifs_pkg::CSR_MASK_3: mask3_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // One bit per byte value, bit n for value n
   assign mask_all  = {mask3_ff, mask2_ff, mask1_ff, mask0_ff};
   assign is_member = mask_all[text_byte];
   assign is_white  = (text_byte == ifs_pkg::CHAR_SPACE) ||
                      (text_byte == ifs_pkg::CHAR_TAB) ||
                      (text_byte == ifs_pkg::CHAR_NEWLINE);

   always_comb begin
      if (!is_member)    byte_cls = ifs_pkg::CLS_OTHER;
      else if (is_white) byte_cls = ifs_pkg::CLS_WHITE;
      else               byte_cls = ifs_pkg::CLS_NONWHITE;
   end

endmodule

>>> rtl/core/ifs_field_splitter.sv
// Top level of the IFS field splitter: input register, split logic, result register.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | ifs_pkg::req_payload_type
//  rsp     | out       | rsp_valid/rsp_ready  | ifs_pkg::rsp_payload_type
//  csr     | in        | csr_we (no wait)     | csr_index, csr_wdata (64 bit)
//
// One byte per cycle sustained while rsp_ready holds; a transfer loads the input register, and
// its result loads the result register when the held item advances.
// Synchronous active-high reset clears both valids, mode and count, and restores the masks.
// A stalled result holds the result register; the input register drains into it
// as soon as it is taken, so back-to-back transfers continue without a bubble.
module ifs_field_splitter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ifs_pkg::req_payload_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ifs_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_we,
   input  logic [ifs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ifs_pkg::MASK_W-1:0]      csr_wdata
);

   logic                          req_valid_ff;
   ifs_pkg::req_payload_type      req_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   ifs_pkg::rsp_payload_type      rsp_data_ff, rsp_data_in;
   ifs_pkg::mode_type             mode_ff, mode_in;
   logic [ifs_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [ifs_pkg::COUNT_W-1:0]   count_sat;
   ifs_pkg::cls_type              byte_cls;
   logic                          emit;
   logic                          advance;

   ifs_classifier u_classifier (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .text_byte (req_data_ff.text_byte),
      .byte_cls  (byte_cls)
   );

   // Handshake: held item moves on when the result register is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign count_sat = (count_ff == ifs_pkg::COUNT_MAX) ? count_ff
                                                      : count_ff + 1'b1;

   // Split rule for the held item
   always_comb begin
      emit        = 1'b0;
      rsp_data_in = '0;
      mode_in     = mode_ff;
      count_in    = count_ff;
      if (req_data_ff.action == ifs_pkg::ACT_END) begin
         emit                 = 1'b1;
         rsp_data_in.text_end = 1'b1;
         if (mode_ff == ifs_pkg::MODE_FIELD) begin
            rsp_data_in.field_end   = 1'b1;
            rsp_data_in.field_total = count_sat;
         end else begin
            rsp_data_in.field_total = count_ff;
         end
         mode_in  = ifs_pkg::MODE_LEAD;
         count_in = '0;
      end else if (req_data_ff.text_byte != ifs_pkg::CHAR_NUL) begin
         case (byte_cls)
            ifs_pkg::CLS_OTHER: begin
               emit                 = 1'b1;
               rsp_data_in.has_byte = 1'b1;
               rsp_data_in.out_byte = req_data_ff.text_byte;
               mode_in              = ifs_pkg::MODE_FIELD;
            end
            ifs_pkg::CLS_WHITE: begin
               if (mode_ff == ifs_pkg::MODE_FIELD) begin
                  emit                  = 1'b1;
                  rsp_data_in.field_end = 1'b1;
                  count_in              = count_sat;
                  mode_in               = ifs_pkg::MODE_DELIM_PRE;
               end
            end
            default: begin
               // non-white IFS: joins a pending white delimiter, else closes a field
               mode_in = ifs_pkg::MODE_DELIM_POST;
               if (mode_ff != ifs_pkg::MODE_DELIM_PRE) begin
                  emit                  = 1'b1;
                  rsp_data_in.field_end = 1'b1;
                  count_in              = count_sat;
               end
            end
         endcase
      end
   end

   assign rsp_valid_in = advance ? emit : (rsp_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= ifs_pkg::MODE_LEAD;
         count_ff     <= '0;
      end else begin
         if (req_ready) req_valid_ff <= req_valid;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_data_ff <= req_payload;
      if (advance && emit)        rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> tb/sv/ifs_field_splitter_test.sv
// Self-checking testbench of the IFS field splitter: table of directed cases, then random texts.
`timescale 1ns / 1ps

module ifs_field_splitter_test;
   import ifs_pkg::*;

   localparam int unsigned QUIET_CYCLES = 6;         // covers the two-stage pipeline
   localparam int unsigned CYCLE_LIMIT  = 600_000;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned PHASE_ITEMS  = 300;

   typedef enum {ROW_TEXT, ROW_MASK} row_kind_type;
   typedef enum {EXP_NONE, EXP_MODEL, EXP_TYPED} exp_kind_type;

   typedef struct {
      row_kind_type         kind;
      req_payload_type      item;
      exp_kind_type         how;
      rsp_payload_type      typed;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [MASK_W-1:0]    reg_val;
   } plan_row_type;

   // Block ports
   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MASK_0;
   logic [MASK_W-1:0]    csr_wdata = '0;

   // Predicted state of the splitter
   logic [MASK_W-1:0]    mask_q [4] = '{MASK_0_RESET, MASK_N_RESET, MASK_N_RESET, MASK_N_RESET};
   mode_type             split_state = MODE_LEAD;
   logic [COUNT_W-1:0]   field_count = '0;

   rsp_payload_type      awaited_rsp [$];
   int unsigned          fail_count = 0;
   int unsigned          cycle_count = 0;
   bit                   req_idle_on = 1'b1;
   bit                   rsp_idle_on = 1'b1;
   int unsigned          rsp_hold = 0;

   ifs_field_splitter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Class of a byte under the current masks
   function automatic cls_type class_of(input logic [BYTE_W-1:0] b);
      if (!mask_q[b[7:6]][b[5:0]])
         return CLS_OTHER;
      if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NEWLINE)
         return CLS_WHITE;
      return CLS_NONWHITE;
   endfunction

   function automatic void close_field();
      if (field_count != COUNT_MAX)
         field_count++;
   endfunction

   // Advance the predicted splitter by one transfer; returns 1 when a result follows
   function automatic bit next_split_result(input req_payload_type item,
                                            output rsp_payload_type res);
      cls_type cls;
      res = '0;
      if (item.action == ACT_END) begin
         if (split_state == MODE_FIELD) begin
            close_field();
            res.field_end = 1'b1;
         end
         res.text_end    = 1'b1;
         res.field_total = field_count;
         split_state     = MODE_LEAD;
         field_count     = '0;
         return 1'b1;
      end
      if (item.text_byte == CHAR_NUL)
         return 1'b0;
      cls = class_of(item.text_byte);
      case (cls)
         CLS_OTHER: begin
            split_state  = MODE_FIELD;
            res.has_byte = 1'b1;
            res.out_byte = item.text_byte;
            return 1'b1;
         end
         CLS_WHITE: begin
            if (split_state != MODE_FIELD)
               return 1'b0;
            close_field();
            split_state   = MODE_DELIM_PRE;
            res.field_end = 1'b1;
            return 1'b1;
         end
         default: begin
            // non-white byte merges into a white run, else it closes a field
            if (split_state == MODE_DELIM_PRE) begin
               split_state = MODE_DELIM_POST;
               return 1'b0;
            end
            close_field();
            split_state   = MODE_DELIM_POST;
            res.field_end = 1'b1;
            return 1'b1;
         end
      endcase
   endfunction

   // Random byte of the wanted class, plain random if none turns up
   function automatic logic [BYTE_W-1:0] pick_byte(input cls_type want);
      logic [BYTE_W-1:0] b;
      int n;
      b = 8'($urandom_range(1, 255));
      for (n = 0; n < 64 && class_of(b) != want; n++)
         b = 8'($urandom_range(1, 255));
      return b;
   endfunction

   // Table row builders
   function automatic plan_row_type text_row(input logic act, input logic [BYTE_W-1:0] b,
                                             input exp_kind_type how);
      plan_row_type row;
      row = '{ROW_TEXT, '{act, b}, how, '0, CSR_MASK_0, '0};
      return row;
   endfunction

   function automatic plan_row_type typed_row(input logic act, input logic [BYTE_W-1:0] b,
                                              input logic hb, input logic fe, input logic te,
                                              input logic [COUNT_W-1:0] total);
      plan_row_type row;
      row = text_row(act, b, EXP_TYPED);
      row.typed = '{hb, hb ? b : 8'h00, fe, te, total};
      return row;
   endfunction

   function automatic plan_row_type mask_row(input logic [CSR_IDX_W-1:0] idx,
                                             input logic [MASK_W-1:0] val);
      plan_row_type row;
      row = '{ROW_MASK, '0, EXP_NONE, '0, idx, val};
      return row;
   endfunction

   // One transfer on the request side, with a random gap in front
   task automatic send_item(input req_payload_type item, input exp_kind_type how,
                            input rsp_payload_type typed);
      int unsigned gap;
      rsp_payload_type res;
      bit produced;
      gap = req_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      produced = next_split_result(item, res);
      case (how)
         EXP_MODEL: if (produced) awaited_rsp.push_back(res);
         EXP_TYPED: awaited_rsp.push_back(typed);
         default: ;
      endcase
   endtask

   // Mask write, only once the block has gone quiet
   task automatic write_mask(input logic [CSR_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      mask_q[idx] = val;
      csr_we <= 1'b0;
   endtask

   // Result side: check each transfer, then stall for a random count
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("result with nothing awaited: %p", rsp_payload);
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_payload.has_byte !== want.has_byte) begin
               $error("has_byte: expected %0d, got %0d", want.has_byte, rsp_payload.has_byte);
               fail_count++;
            end
            if (rsp_payload.out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_payload.out_byte);
               fail_count++;
            end
            if (rsp_payload.field_end !== want.field_end) begin
               $error("field_end: expected %0d, got %0d", want.field_end,
                      rsp_payload.field_end);
               fail_count++;
            end
            if (rsp_payload.text_end !== want.text_end) begin
               $error("text_end: expected %0d, got %0d", want.text_end, rsp_payload.text_end);
               fail_count++;
            end
            if (rsp_payload.field_total !== want.field_total) begin
               $error("field_total: expected %0d, got %0d", want.field_total,
                      rsp_payload.field_total);
               fail_count++;
            end
         end
         if ($urandom_range(0, 39) == 0)
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         rsp_hold = rsp_idle_on ? $urandom_range(0, 11) : 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_ready <= (rsp_hold == 0);
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus
   initial begin
      plan_row_type plan [];
      logic [CSR_IDX_W-1:0] mask_ids [4];
      logic [MASK_W-1:0] vals [4];
      req_payload_type item;
      int unsigned counted;
      int unsigned roll;

      mask_ids = '{CSR_MASK_0, CSR_MASK_1, CSR_MASK_2, CSR_MASK_3};
      plan = '{
         typed_row(ACT_END, 8'h41, 1'b0, 1'b0, 1'b1, 16'd0),       // empty text
         text_row(ACT_BYTE, CHAR_SPACE, EXP_NONE),                 // leading white skipped
         typed_row(ACT_BYTE, 8'h61, 1'b1, 1'b0, 1'b0, 16'd0),
         text_row(ACT_BYTE, CHAR_NUL, EXP_NONE),                   // zero byte ignored
         typed_row(ACT_BYTE, CHAR_TAB, 1'b0, 1'b1, 1'b0, 16'd0),   // white closes the field
         text_row(ACT_BYTE, CHAR_NEWLINE, EXP_NONE),               // white run is one delimiter
         typed_row(ACT_BYTE, 8'hFF, 1'b1, 1'b0, 1'b0, 16'd0),
         typed_row(ACT_BYTE, 8'h01, 1'b1, 1'b0, 1'b0, 16'd0),
         typed_row(ACT_END, 8'hFE, 1'b0, 1'b1, 1'b1, 16'd2),       // end inside a field
         text_row(ACT_BYTE, CHAR_NEWLINE, EXP_NONE),
         typed_row(ACT_END, CHAR_NUL, 1'b0, 1'b0, 1'b1, 16'd0),    // only white
         // ':' and 0x7C, 0x80, 0xFF become non-white delimiters
         mask_row(CSR_MASK_0, 64'h0400_0001_0000_0600),
         mask_row(CSR_MASK_1, 64'h1000_0000_0000_0000),
         mask_row(CSR_MASK_2, 64'h0000_0000_0000_0001),
         mask_row(CSR_MASK_3, 64'h8000_0000_0000_0000),
         typed_row(ACT_BYTE, 8'h3A, 1'b0, 1'b1, 1'b0, 16'd0),      // leading non-white: empty
         typed_row(ACT_BYTE, 8'h3A, 1'b0, 1'b1, 1'b0, 16'd0),      // adjacent one: another
         text_row(ACT_BYTE, CHAR_SPACE, EXP_NONE),
         typed_row(ACT_BYTE, 8'h78, 1'b1, 1'b0, 1'b0, 16'd0),
         text_row(ACT_BYTE, CHAR_SPACE, EXP_MODEL),
         text_row(ACT_BYTE, 8'hFF, EXP_MODEL),                     // joins the white run
         text_row(ACT_BYTE, CHAR_TAB, EXP_MODEL),
         text_row(ACT_BYTE, 8'h80, EXP_MODEL),                     // second non-white: empty
         text_row(ACT_BYTE, 8'h79, EXP_MODEL),
         text_row(ACT_BYTE, 8'h7C, EXP_MODEL),
         typed_row(ACT_END, 8'h7F, 1'b0, 1'b0, 1'b1, 16'd5),       // trailing delimiter: none
         mask_row(CSR_MASK_0, 64'h0),
         typed_row(ACT_BYTE, CHAR_SPACE, 1'b1, 1'b0, 1'b0, 16'd0), // space outside the mask
         typed_row(ACT_END, 8'h80, 1'b0, 1'b1, 1'b1, 16'd1)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_MASK)
            write_mask(plan[i].reg_idx, plan[i].reg_val);
         else
            send_item(plan[i].item, plan[i].how, plan[i].typed);
      end

      // Random texts under several mask settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: vals = '{'0, '0, '0, '0};
            1: vals = '{'1, '1, '1, '1};
            2: vals = '{MASK_0_RESET, MASK_N_RESET, MASK_N_RESET, MASK_N_RESET};
            default: begin
               foreach (vals[r])
                  vals[r] = {$urandom, $urandom} & {$urandom, $urandom};
               vals[0] = vals[0] | (MASK_0_RESET & {$urandom, $urandom});
            end
         endcase
         foreach (vals[r])
            write_mask(mask_ids[r], vals[r]);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if (counted % 40 == 0)
               req_idle_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            item.action = ACT_BYTE;
            if (roll < 8) begin
               item.action    = ACT_END;
               item.text_byte = 8'($urandom_range(0, 255));
            end else if (roll < 11) begin
               item.text_byte = CHAR_NUL;
            end else if (roll < 41) begin
               case ($urandom_range(0, 2))
                  0: item.text_byte = CHAR_SPACE;
                  1: item.text_byte = CHAR_TAB;
                  default: item.text_byte = CHAR_NEWLINE;
               endcase
            end else if (roll < 61) begin
               item.text_byte = pick_byte(CLS_NONWHITE);
            end else begin
               item.text_byte = pick_byte(CLS_OTHER);
            end
            if (item.action == ACT_END || item.text_byte != CHAR_NUL)
               counted++;
            send_item(item, EXP_MODEL, '0);
         end
      end
      send_item('{ACT_END, 8'hC3}, EXP_MODEL, '0);

      // Drain and finish
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
